// ----- hw/rtl/whs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whs_pkg
// Shared constants, codes and control types of the 64-bit word stream hash.
// ----------------------------------------------------------------------------
package whs_pkg;

	localparam int          LENGTH_BITS = 32;
	localparam logic [31:0] LEN_MASK    = (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF :
	                                      32'((64'd1 << LENGTH_BITS) - 64'd1);
	localparam logic [63:0] MUL_C       = 64'hc6a4_a793_5bd1_e995;
	localparam int          SHIFT_C     = 47;

	// multiplier operand select
	localparam logic [2:0] OP_LEN  = 3'd0;
	localparam logic [2:0] OP_WORD = 3'd1;
	localparam logic [2:0] OP_PART = 3'd2;
	localparam logic [2:0] OP_XSH  = 3'd3;
	localparam logic [2:0] OP_HXK  = 3'd4;

	typedef struct packed {
		logic       load;
		logic       start;
		logic [2:0] opsel;
		logic       wb_seed;
		logic       wb_h;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic mul_busy;
		logic tail_nz;
	} status_t;

endpackage

// ----- hw/rtl/whs_msg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whs_msg_if
// Message word channel: one request carries one 64-bit word and its flags.
// ----------------------------------------------------------------------------
interface whs_msg_if;
	logic        valid;
	logic        ready;
	logic [63:0] word;
	logic [31:0] message_length;
	logic        first;
	logic        last;

	modport source (output valid, output word, output message_length,
		output first, output last, input ready);
	modport sink (input valid, input word, input message_length,
		input first, input last, output ready);
endinterface

// ----- hw/rtl/whs_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whs_res_if
// Result channel: one request carries one finalized 64-bit hash.
// ----------------------------------------------------------------------------
interface whs_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash;

	modport source (output valid, output hash, input ready);
	modport sink (input valid, input hash, output ready);
endinterface

// ----- hw/rtl/whs_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whs_mul
// Iterative 64-bit multiply by the hash constant, low 64 bits of the product,
// one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module whs_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	output logic        busy,
	output logic        done,
	output logic [63:0] result
);

	logic [1:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [31:0] x;
	logic [31:0] y;
	logic [63:0] prod;

	always_comb begin
		case (cnt_q)
			2'd0: begin
				x = a_q[31:0];
				y = whs_pkg::MUL_C[31:0];
			end
			2'd1: begin
				x = a_q[31:0];
				y = whs_pkg::MUL_C[63:32];
			end
			default: begin
				x = a_q[63:32];
				y = whs_pkg::MUL_C[31:0];
			end
		endcase
	end

	assign prod = 64'(x) * 64'(y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == 2'd2);
			if (start) begin
				cnt_q <= 2'd0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (cnt_q == 2'd2) begin
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
		end
		if (run_q) begin
			if (cnt_q == 2'd0) begin
				acc_q <= prod;
			end else begin
				acc_q <= acc_q + {prod[31:0], 32'd0};
			end
		end
	end

	assign busy   = run_q;
	assign done   = done_q;
	assign result = acc_q;

endmodule

// ----- hw/rtl/whs_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whs_dp
// Hash datapath: word and length capture, running hash, tail size,
// multiplier operand selection and the result register.
// ----------------------------------------------------------------------------
module whs_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  whs_pkg::cmd_t    cmd,
	output whs_pkg::status_t st,
	input  logic [63:0]      seed,
	input  logic [63:0]      word,
	input  logic [31:0]      message_length,
	output logic [63:0]      hash
);

	logic [63:0] word_q;
	logic [31:0] len_q;
	logic [63:0] h_q;
	logic [2:0]  tail_q;
	logic [63:0] hash_q;
	logic [63:0] opnd;
	logic [63:0] keep;
	logic [63:0] acc;
	logic [63:0] acc_xsh;
	logic        mul_done;
	logic        mul_busy;

	assign keep    = ~(64'hFFFF_FFFF_FFFF_FFFF << {tail_q, 3'b000});
	assign acc_xsh = acc ^ (acc >> whs_pkg::SHIFT_C);

	always_comb begin
		case (cmd.opsel)
			whs_pkg::OP_LEN:  opnd = {32'd0, len_q};
			whs_pkg::OP_WORD: opnd = word_q;
			whs_pkg::OP_PART: opnd = h_q ^ (word_q & keep);
			whs_pkg::OP_XSH:  opnd = acc_xsh;
			whs_pkg::OP_HXK:  opnd = h_q ^ acc;
			default:          opnd = word_q;
		endcase
	end

	whs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.a      (opnd),
		.busy   (mul_busy),
		.done   (mul_done),
		.result (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= 64'd0;
			tail_q <= 3'd0;
		end else begin
			if (cmd.wb_seed) begin
				h_q    <= seed ^ acc;
				tail_q <= len_q[2:0];
			end else if (cmd.wb_h) begin
				h_q <= acc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= word;
			len_q  <= message_length & whs_pkg::LEN_MASK;
		end
		if (cmd.out_load) begin
			hash_q <= acc_xsh;
		end
	end

	assign st.mul_done = mul_done;
	assign st.mul_busy = mul_busy;
	assign st.tail_nz  = (tail_q != 3'd0);
	assign hash        = hash_q;

endmodule

// ----- hw/rtl/whs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whs_ctrl
// Sequencer: orders seeding, word mixing, fold-in and finalization, and owns
// the input ready and the result valid.
// ----------------------------------------------------------------------------
module whs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_first,
	input  logic             in_last,
	output logic             out_valid,
	input  logic             out_ready,
	output whs_pkg::cmd_t    cmd,
	input  whs_pkg::status_t st
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SEED   = 4'd1;
	localparam logic [3:0] S_SEED_W = 4'd2;
	localparam logic [3:0] S_BRANCH = 4'd3;
	localparam logic [3:0] S_K1_W   = 4'd4;
	localparam logic [3:0] S_K2_W   = 4'd5;
	localparam logic [3:0] S_H_W    = 4'd6;
	localparam logic [3:0] S_FIN_W  = 4'd7;
	localparam logic [3:0] S_OUT    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       last_q;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd      = '0;
		cmd.load = accept;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = in_first ? S_SEED : S_BRANCH;
				end
			end
			S_SEED: begin
				cmd.start = 1'b1;
				cmd.opsel = whs_pkg::OP_LEN;
				state_d   = S_SEED_W;
			end
			S_SEED_W: begin
				if (st.mul_done) begin
					cmd.wb_seed = 1'b1;
					state_d     = S_BRANCH;
				end
			end
			S_BRANCH: begin
				cmd.start = 1'b1;
				if (last_q && st.tail_nz) begin
					cmd.opsel = whs_pkg::OP_PART;
					state_d   = S_H_W;
				end else begin
					cmd.opsel = whs_pkg::OP_WORD;
					state_d   = S_K1_W;
				end
			end
			S_K1_W: begin
				if (st.mul_done) begin
					cmd.start = 1'b1;
					cmd.opsel = whs_pkg::OP_XSH;
					state_d   = S_K2_W;
				end
			end
			S_K2_W: begin
				if (st.mul_done) begin
					cmd.start = 1'b1;
					cmd.opsel = whs_pkg::OP_HXK;
					state_d   = S_H_W;
				end
			end
			S_H_W: begin
				if (st.mul_done) begin
					cmd.wb_h = 1'b1;
					if (last_q) begin
						cmd.start = 1'b1;
						cmd.opsel = whs_pkg::OP_XSH;
						state_d   = S_FIN_W;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_FIN_W: begin
				if (st.mul_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q <= in_last;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/word_stream_hash_64.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_stream_hash_64
// 64-bit multiply-xorshift hash over a message streamed as 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   msg  : one request per little-endian word; first marks the opening word
//          and brings message_length, last marks the closing word.
//   res  : one request per message, holding the finalized hash.
//   APB  : seed register at address 0, 64-bit data; user writes it only while idle (not enforced).
// Multiply: every 64-bit multiply runs on one shared 32x32 unit. A first word
//   adds seeding; a last word adds finalization and the output load.
// Stall: the result sits in an output register; the next word is accepted
//   while it waits, and the next result is held back until the slot frees.
// Reset: seed, running hash and tail size clear to zero; no result pending.
// ----------------------------------------------------------------------------
module word_stream_hash_64 (
	input  logic        clk,
	input  logic        arst_n,
	whs_msg_if.sink     msg,
	whs_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [63:0]      seed_q;
	whs_pkg::cmd_t    cmd;
	whs_pkg::status_t st;

	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? seed_q : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 64'd0;
		end else if (psel && penable && pwrite && pready && (paddr == 3'd0)) begin
			seed_q <= pwdata;
		end
	end

	whs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (msg.valid),
		.in_ready  (msg.ready),
		.in_first  (msg.first),
		.in_last   (msg.last),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (cmd),
		.st        (st)
	);

	whs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.seed           (seed_q),
		.word           (msg.word),
		.message_length (msg.message_length),
		.hash           (res.hash)
	);

`ifndef SYNTHESIS
	a_ready_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		msg.ready |-> !st.mul_busy)
		else $error("word accepted while multiplier busy");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!res.valid || res.ready))
		else $error("result overwritten before delivery");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !st.mul_busy)
		else $error("multiply started while previous one runs");
`endif

endmodule
